// ----- src/gpsc_pkg.sv -----
// Shared widths, register indexes, bit positions and constants of the gamepad conditioner.
package gpsc_pkg;

    // Field widths.
    localparam int BTN_W   = 14;
    localparam int TRIG_W  = 15;
    localparam int STICK_W = 16;
    localparam int MASK_W  = 12;
    localparam int AXIS_W  = 16;
    localparam int CFG_W   = 15;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

    // Register reset values.
    localparam logic [CFG_W-1:0] DEADZONE_RST  = 15'd8000;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 15'd16000;

    // Full scale of an axis.
    localparam logic [14:0] FULL_SCALE = 15'd32767;

    // Input button bit positions.
    localparam int BTN_A     = 0;
    localparam int BTN_B     = 1;
    localparam int BTN_X     = 2;
    localparam int BTN_Y     = 3;
    localparam int BTN_LB    = 4;
    localparam int BTN_RB    = 5;
    localparam int BTN_LS    = 6;
    localparam int BTN_RS    = 7;
    localparam int BTN_START = 8;
    localparam int BTN_BACK  = 9;
    localparam int BTN_LEFT  = 10;
    localparam int BTN_RIGHT = 11;
    localparam int BTN_UP    = 12;
    localparam int BTN_DOWN  = 13;

    // Engine mask bit positions.
    localparam int MSK_L2    = 0;
    localparam int MSK_R2    = 1;
    localparam int MSK_L1    = 2;
    localparam int MSK_R1    = 3;
    localparam int MSK_SOUTH = 4;
    localparam int MSK_EAST  = 5;
    localparam int MSK_WEST  = 6;
    localparam int MSK_NORTH = 7;
    localparam int MSK_L3    = 9;
    localparam int MSK_R3    = 10;
    localparam int MSK_START = 11;

endpackage

// ----- src/gpsc_in_if.sv -----
// Input channel of the gamepad conditioner: one controller sample per word.
interface gpsc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                pad_present;
    logic [gpsc_pkg::BTN_W-1:0]          buttons;
    logic [gpsc_pkg::TRIG_W-1:0]         trigger_left;
    logic [gpsc_pkg::TRIG_W-1:0]         trigger_right;
    logic signed [gpsc_pkg::STICK_W-1:0] stick_x;
    logic signed [gpsc_pkg::STICK_W-1:0] stick_y;

    modport source (
        output valid, pad_present, buttons, trigger_left, trigger_right, stick_x, stick_y,
        input  ready
    );
    modport sink (
        input  valid, pad_present, buttons, trigger_left, trigger_right, stick_x, stick_y,
        output ready
    );
endinterface

// ----- src/gpsc_out_if.sv -----
// Output channel of the gamepad conditioner: one conditioned sample per word.
interface gpsc_out_if;
    logic                               valid;
    logic                               ready;
    logic [gpsc_pkg::MASK_W-1:0]        button_mask;
    logic signed [gpsc_pkg::AXIS_W-1:0] axis_x;
    logic signed [gpsc_pkg::AXIS_W-1:0] axis_y;
    logic                               back_event;

    modport source (
        output valid, button_mask, axis_x, axis_y, back_event,
        input  ready
    );
    modport sink (
        input  valid, button_mask, axis_x, axis_y, back_event,
        output ready
    );
endinterface

// ----- src/gamepad_stick_and_button_conditioner.sv -----
// Top level of the gamepad stick and button conditioner.
// One controller sample is taken per word. Buttons and triggers are packed into the engine
// mask at once, the stick is deadzoned and mapped from circle to square with bit-serial
// arithmetic: shift-add squaring, digit-by-digit square root, shift-add scaling and
// restoring division, both axes in parallel lanes, then a final step to clamp and apply
// the D-pad. The input is ready only in the idle state, so a new sample is not taken
// until the last one is through. A sample with the stick at rest skips the arithmetic
// and goes straight to the final step, and a sample without a pad gives no result.
// The output register holds a finished word while the next sample is being worked on;
// while it is still full, the next finished word waits and the input stays stalled.
module gamepad_stick_and_button_conditioner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gpsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gpsc_pkg::CFG_W-1:0]         i_cfg_data,
    gpsc_in_if.sink                            i_in,
    gpsc_out_if.source                         o_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // Control state.
    logic [2:0]  r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_back_was, n_back_was;
    logic        r_out_valid, n_out_valid;
    logic [gpsc_pkg::CFG_W-1:0] r_deadzone, r_threshold;

    // Per-sample working registers.
    logic [15:0] r_ax, n_ax, r_ay, n_ay, r_m, n_m;
    logic        r_neg_x, n_neg_x, r_neg_y, n_neg_y;
    logic [gpsc_pkg::MASK_W-1:0] r_mask, n_mask;
    logic [3:0]  r_dpad, n_dpad;
    logic        r_event, n_event;
    logic [31:0] r_mcand_x, n_mcand_x, r_mcand_y, n_mcand_y;
    logic [15:0] r_mplr_x, n_mplr_x, r_mplr_y, n_mplr_y;
    logic [31:0] r_acc_x, n_acc_x, r_acc_y, n_acc_y;
    logic [31:0] r_rad, n_rad, r_root, n_root, r_bit, n_bit;
    logic [15:0] r_rem_x, n_rem_x, r_rem_y, n_rem_y;

    // Output register.
    logic [gpsc_pkg::MASK_W-1:0]        r_o_mask, n_o_mask;
    logic signed [gpsc_pkg::AXIS_W-1:0] r_o_x, n_o_x, r_o_y, n_o_y;
    logic                               r_o_event, n_o_event;

    // Combinational helpers.
    logic        accept;
    logic [15:0] mag_x, mag_y, dz_x, dz_y;
    logic        pass_x, pass_y;
    logic [31:0] root_try;
    logic [16:0] div_tx, div_ty;
    logic        ge_x, ge_y;
    logic [14:0] qc_x, qc_y;
    logic [15:0] ax_out, ay_out;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && (r_state == ST_IDLE);

    // Stick magnitude and deadzone; -32768 gives a magnitude of 32768.
    assign mag_x  = i_in.stick_x[15] ? (~i_in.stick_x + 16'd1) : i_in.stick_x;
    assign mag_y  = i_in.stick_y[15] ? (~i_in.stick_y + 16'd1) : i_in.stick_y;
    assign pass_x = mag_x > {1'b0, r_deadzone};
    assign pass_y = mag_y > {1'b0, r_deadzone};
    assign dz_x   = pass_x ? mag_x : 16'd0;
    assign dz_y   = pass_y ? mag_y : 16'd0;

    // One square root digit, shared by both lanes, and one division digit per lane.
    assign root_try = r_root + r_bit;
    assign div_tx   = {r_rem_x, r_acc_x[15]};
    assign div_ty   = {r_rem_y, r_acc_y[15]};
    assign ge_x     = div_tx >= {1'b0, r_m};
    assign ge_y     = div_ty >= {1'b0, r_m};

    // Clamp to full scale and restore the sign.
    assign qc_x   = (r_mplr_x > {1'b0, gpsc_pkg::FULL_SCALE}) ? gpsc_pkg::FULL_SCALE
                                                            : r_mplr_x[14:0];
    assign qc_y   = (r_mplr_y > {1'b0, gpsc_pkg::FULL_SCALE}) ? gpsc_pkg::FULL_SCALE
                                                            : r_mplr_y[14:0];
    assign ax_out = r_neg_x ? (16'd0 - {1'b0, qc_x}) : {1'b0, qc_x};
    assign ay_out = r_neg_y ? (16'd0 - {1'b0, qc_y}) : {1'b0, qc_y};

    // Sequencer and datapath next values.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_back_was  = r_back_was;
        n_out_valid = r_out_valid;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_m         = r_m;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_mask      = r_mask;
        n_dpad      = r_dpad;
        n_event     = r_event;
        n_mcand_x   = r_mcand_x;
        n_mcand_y   = r_mcand_y;
        n_mplr_x    = r_mplr_x;
        n_mplr_y    = r_mplr_y;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_rad       = r_rad;
        n_root      = r_root;
        n_bit       = r_bit;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_o_mask    = r_o_mask;
        n_o_x       = r_o_x;
        n_o_y       = r_o_y;
        n_o_event   = r_o_event;

        // The consumer frees the output register.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_in.pad_present) begin
                    n_mask = '0;
                    n_mask[gpsc_pkg::MSK_SOUTH] = i_in.buttons[gpsc_pkg::BTN_A];
                    n_mask[gpsc_pkg::MSK_EAST]  = i_in.buttons[gpsc_pkg::BTN_B];
                    n_mask[gpsc_pkg::MSK_WEST]  = i_in.buttons[gpsc_pkg::BTN_X];
                    n_mask[gpsc_pkg::MSK_NORTH] = i_in.buttons[gpsc_pkg::BTN_Y];
                    n_mask[gpsc_pkg::MSK_L1]    = i_in.buttons[gpsc_pkg::BTN_LB];
                    n_mask[gpsc_pkg::MSK_R1]    = i_in.buttons[gpsc_pkg::BTN_RB];
                    n_mask[gpsc_pkg::MSK_L3]    = i_in.buttons[gpsc_pkg::BTN_LS];
                    n_mask[gpsc_pkg::MSK_R3]    = i_in.buttons[gpsc_pkg::BTN_RS];
                    n_mask[gpsc_pkg::MSK_START] = i_in.buttons[gpsc_pkg::BTN_START];
                    n_mask[gpsc_pkg::MSK_L2]    = i_in.trigger_left > r_threshold;
                    n_mask[gpsc_pkg::MSK_R2]    = i_in.trigger_right > r_threshold;
                    n_dpad = {i_in.buttons[gpsc_pkg::BTN_DOWN], i_in.buttons[gpsc_pkg::BTN_UP],
                              i_in.buttons[gpsc_pkg::BTN_RIGHT], i_in.buttons[gpsc_pkg::BTN_LEFT]};
                    n_event    = i_in.buttons[gpsc_pkg::BTN_BACK] && !r_back_was;
                    n_back_was = i_in.buttons[gpsc_pkg::BTN_BACK];
                    n_ax       = dz_x;
                    n_ay       = dz_y;
                    n_neg_x    = pass_x && i_in.stick_x[15];
                    n_neg_y    = pass_y && i_in.stick_y[15];
                    n_m        = (dz_x > dz_y) ? dz_x : dz_y;
                    n_mcand_x  = {16'd0, dz_x};
                    n_mcand_y  = {16'd0, dz_y};
                    n_mplr_x   = dz_x;
                    n_mplr_y   = dz_y;
                    n_acc_x    = '0;
                    n_acc_y    = '0;
                    n_cnt      = 4'd15;
                    // A stick at rest skips the mapping and reads zero.
                    if (dz_x == 16'd0 && dz_y == 16'd0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SQR;
                    end
                end
            end

            ST_SQR: begin
                // Shift-add squaring, one multiplier bit per cycle.
                n_acc_x   = r_acc_x + (r_mplr_x[0] ? r_mcand_x : 32'd0);
                n_acc_y   = r_acc_y + (r_mplr_y[0] ? r_mcand_y : 32'd0);
                n_mcand_x = r_mcand_x << 1;
                n_mcand_y = r_mcand_y << 1;
                n_mplr_x  = r_mplr_x >> 1;
                n_mplr_y  = r_mplr_y >> 1;
                n_cnt     = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_rad   = n_acc_x + n_acc_y;
                    n_root  = '0;
                    n_bit   = 32'h4000_0000;
                    n_cnt   = 4'd15;
                    n_state = ST_ROOT;
                end
            end

            ST_ROOT: begin
                // Digit-by-digit square root, one result bit per cycle.
                if (r_rad >= root_try) begin
                    n_rad  = r_rad - root_try;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_mcand_x = {16'd0, r_ax};
                    n_mcand_y = {16'd0, r_ay};
                    n_mplr_x  = n_root[15:0];
                    n_mplr_y  = n_root[15:0];
                    n_acc_x   = '0;
                    n_acc_y   = '0;
                    n_cnt     = 4'd15;
                    n_state   = ST_MUL;
                end
            end

            ST_MUL: begin
                // Shift-add product of axis magnitude and radius.
                n_acc_x   = r_acc_x + (r_mplr_x[0] ? r_mcand_x : 32'd0);
                n_acc_y   = r_acc_y + (r_mplr_y[0] ? r_mcand_y : 32'd0);
                n_mcand_x = r_mcand_x << 1;
                n_mcand_y = r_mcand_y << 1;
                n_mplr_x  = r_mplr_x >> 1;
                n_mplr_y  = r_mplr_y >> 1;
                n_cnt     = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    // The quotient stays below 2^16, so the upper half is already
                    // a partial remainder below the divisor.
                    n_rem_x = n_acc_x[31:16];
                    n_rem_y = n_acc_y[31:16];
                    n_mplr_x = '0;
                    n_mplr_y = '0;
                    n_cnt   = 4'd15;
                    n_state = ST_DIV;
                end
            end

            ST_DIV: begin
                // Restoring division by the larger magnitude, one quotient bit per cycle.
                n_rem_x  = ge_x ? 16'(div_tx - {1'b0, r_m}) : div_tx[15:0];
                n_rem_y  = ge_y ? 16'(div_ty - {1'b0, r_m}) : div_ty[15:0];
                n_acc_x  = r_acc_x << 1;
                n_acc_y  = r_acc_y << 1;
                n_mplr_x = {r_mplr_x[14:0], ge_x};
                n_mplr_y = {r_mplr_y[14:0], ge_y};
                n_cnt    = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                // Load the result once the output register is free.
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_mask    = r_mask;
                    n_o_event   = r_event;
                    // Right wins over left, down wins over up.
                    if (r_dpad[1]) begin
                        n_o_x = signed'({1'b0, gpsc_pkg::FULL_SCALE});
                    end else if (r_dpad[0]) begin
                        n_o_x = -signed'({1'b0, gpsc_pkg::FULL_SCALE});
                    end else begin
                        n_o_x = signed'(ax_out);
                    end
                    if (r_dpad[3]) begin
                        n_o_y = signed'({1'b0, gpsc_pkg::FULL_SCALE});
                    end else if (r_dpad[2]) begin
                        n_o_y = -signed'({1'b0, gpsc_pkg::FULL_SCALE});
                    end else begin
                        n_o_y = signed'(ay_out);
                    end
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_back_was  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_back_was  <= n_back_was;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone  <= gpsc_pkg::DEADZONE_RST;
            r_threshold <= gpsc_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gpsc_pkg::REG_DEADZONE:  r_deadzone  <= i_cfg_data;
                gpsc_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_m       <= n_m;
        r_neg_x   <= n_neg_x;
        r_neg_y   <= n_neg_y;
        r_mask    <= n_mask;
        r_dpad    <= n_dpad;
        r_event   <= n_event;
        r_mcand_x <= n_mcand_x;
        r_mcand_y <= n_mcand_y;
        r_mplr_x  <= n_mplr_x;
        r_mplr_y  <= n_mplr_y;
        r_acc_x   <= n_acc_x;
        r_acc_y   <= n_acc_y;
        r_rad     <= n_rad;
        r_root    <= n_root;
        r_bit     <= n_bit;
        r_rem_x   <= n_rem_x;
        r_rem_y   <= n_rem_y;
        r_o_mask  <= n_o_mask;
        r_o_x     <= n_o_x;
        r_o_y     <= n_o_y;
        r_o_event <= n_o_event;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.button_mask = r_o_mask;
    assign o_out.axis_x      = r_o_x;
    assign o_out.axis_y      = r_o_y;
    assign o_out.back_event  = r_o_event;

endmodule
